// ===== design/l32dec_pkg.sv =====
// Types, decode tables and the class search for the LA32R instruction decoder.
package l32dec_pkg;

	localparam int NUM_GROUPS  = 23;
	localparam int NUM_CLASSES = 68;

	localparam logic [6:0] CLS_INVALID = 7'd68;

	// operand formats
	localparam logic [4:0] FMT_NONE   = 5'd0;
	localparam logic [4:0] FMT_R3     = 5'd1;
	localparam logic [4:0] FMT_I12S   = 5'd2;
	localparam logic [4:0] FMT_I12U   = 5'd3;
	localparam logic [4:0] FMT_I14S   = 5'd4;
	localparam logic [4:0] FMT_CSR    = 5'd5;
	localparam logic [4:0] FMT_BR     = 5'd6;
	localparam logic [4:0] FMT_B      = 5'd7;
	localparam logic [4:0] FMT_BL     = 5'd8;
	localparam logic [4:0] FMT_JIRL   = 5'd9;
	localparam logic [4:0] FMT_I5     = 5'd10;
	localparam logic [4:0] FMT_PCADD  = 5'd11;
	localparam logic [4:0] FMT_LU12I  = 5'd12;
	localparam logic [4:0] FMT_R2     = 5'd13;
	localparam logic [4:0] FMT_CODE   = 5'd14;
	localparam logic [4:0] FMT_INVTLB = 5'd15;
	localparam logic [4:0] FMT_CACOP  = 5'd16;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] fetch_pc;
	} item_t;

	typedef struct packed {
		logic               fetch_misaligned;
		logic [6:0]         instr_class;
		logic [4:0]         dest_reg;
		logic               dest_write;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
		logic [31:0]        target_addr;
		logic [31:0]        link_addr;
	} result_t;

	localparam logic [31:0] GRP_MASK [NUM_GROUPS] = '{
		32'hFFF00000, 32'hF0000000, 32'hC0000000, 32'hFE000000,
		32'hFFC00000, 32'hFE000000, 32'hFE000000, 32'hFFF80000,
		32'hFF000000, 32'hFFFFC000, 32'hFFFF8000, 32'hFFFF8000,
		32'hFFFF8000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
		32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF8000, 32'hFFFF8000,
		32'hFFFF8000, 32'hFFC00000, 32'hFFFFFFFF
	};

	localparam logic [31:0] GRP_MATCH [NUM_GROUPS] = '{
		32'h00100000, 32'h20000000, 32'h40000000, 32'h02000000,
		32'h00400000, 32'h1C000000, 32'h14000000, 32'h00200000,
		32'h04000000, 32'h00004000, 32'h002B0000, 32'h002A0000,
		32'h06488000, 32'h06483800, 32'h06482800, 32'h06482C00,
		32'h06483000, 32'h06483400, 32'h06498000, 32'h38720000,
		32'h38728000, 32'h06000000, 32'h80000000
	};

	localparam logic [6:0] GRP_FIRST [NUM_GROUPS] = '{
		7'd0, 7'd14, 7'd25, 7'd34, 7'd40, 7'd43, 7'd44, 7'd45,
		7'd49, 7'd52, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60,
		7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67
	};

	localparam logic [6:0] GRP_COUNT [NUM_GROUPS] = '{
		7'd14, 7'd11, 7'd9, 7'd6, 7'd3, 7'd1, 7'd1, 7'd4,
		7'd3, 7'd3, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
		7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1
	};

	localparam logic [31:0] CLS_MASK [NUM_CLASSES] = '{
		32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000,
		32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000,
		32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000,
		32'h000F8000, 32'h000F8000,
		32'h0FC00000, 32'h0FC00000, 32'h0FC00000, 32'h0FC00000,
		32'h0FC00000, 32'h0FC00000, 32'h0FC00000, 32'h0FC00000,
		32'h0FC00000, 32'h0F000000, 32'h0F000000,
		32'h3C000000, 32'h3C000000, 32'h3C000000, 32'h3C000000,
		32'h3C000000, 32'h3C000000, 32'h3C000000, 32'h3C000000,
		32'h3C000000,
		32'h01C00000, 32'h01C00000, 32'h01C00000, 32'h01C00000,
		32'h01C00000, 32'h01C00000,
		32'h003F8000, 32'h003F8000, 32'h003F8000,
		32'h00000000, 32'h00000000,
		32'h00078000, 32'h00078000, 32'h00078000, 32'h00078000,
		32'h000003E0, 32'h000003E0, 32'h00000000,
		32'h00003FE0, 32'h00003FE0, 32'h00003C1F,
		32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000
	};

	localparam logic [31:0] CLS_MATCH [NUM_CLASSES] = '{
		32'h00000000, 32'h00010000, 32'h00048000, 32'h00050000,
		32'h00058000, 32'h00040000, 32'h00020000, 32'h00028000,
		32'h00070000, 32'h00078000, 32'h00080000, 32'h000C0000,
		32'h000C8000, 32'h000D0000,
		32'h08800000, 32'h09800000, 32'h08400000, 32'h0A400000,
		32'h09400000, 32'h08000000, 32'h0A000000, 32'h09000000,
		32'h0AC00000, 32'h00000000, 32'h01000000,
		32'h10000000, 32'h2C000000, 32'h1C000000, 32'h24000000,
		32'h20000000, 32'h18000000, 32'h28000000, 32'h14000000,
		32'h0C000000,
		32'h00800000, 32'h00000000, 32'h01400000, 32'h01800000,
		32'h01C00000, 32'h00400000,
		32'h00008000, 32'h00048000, 32'h00088000,
		32'h00000000, 32'h00000000,
		32'h00000000, 32'h00010000, 32'h00008000, 32'h00018000,
		32'h00000000, 32'h00000020, 32'h00000000,
		32'h00002000, 32'h00002400, 32'h00002000,
		32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000
	};

	localparam logic [4:0] CLS_FMT [NUM_CLASSES] = '{
		FMT_R3, FMT_R3, FMT_R3, FMT_R3, FMT_R3, FMT_R3, FMT_R3, FMT_R3,
		FMT_R3, FMT_R3, FMT_R3, FMT_R3, FMT_R3, FMT_R3,
		FMT_I12S, FMT_I12S, FMT_I12S, FMT_I12S, FMT_I12S, FMT_I12S,
		FMT_I12S, FMT_I12S, FMT_I12S, FMT_I14S, FMT_I14S,
		FMT_B, FMT_BR, FMT_BR, FMT_BR, FMT_BR, FMT_BR, FMT_BR, FMT_BL,
		FMT_JIRL,
		FMT_I12S, FMT_I12S, FMT_I12U, FMT_I12U, FMT_I12U, FMT_I12S,
		FMT_I5, FMT_I5, FMT_I5,
		FMT_PCADD, FMT_LU12I,
		FMT_R3, FMT_R3, FMT_R3, FMT_R3,
		FMT_CSR, FMT_CSR, FMT_CSR,
		FMT_R2, FMT_R2, FMT_R2,
		FMT_CODE, FMT_CODE, FMT_CODE,
		FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE,
		FMT_INVTLB, FMT_NONE, FMT_NONE, FMT_CACOP, FMT_NONE
	};

	// First matching group wins; a miss inside that group is invalid.
	function automatic logic [6:0] find_class(input logic [31:0] w);
		logic       grp_hit;
		logic [4:0] gsel;
		logic       cls_hit;
		logic [6:0] cls;
		logic [7:0] lo;
		logic [7:0] hi;
		grp_hit = 1'b0;
		gsel    = '0;
		cls_hit = 1'b0;
		cls     = CLS_INVALID;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (!grp_hit && ((w & GRP_MASK[g]) == GRP_MATCH[g])) begin
				grp_hit = 1'b1;
				gsel    = 5'(g);
			end
		end
		lo = {1'b0, GRP_FIRST[gsel]};
		hi = {1'b0, GRP_FIRST[gsel]} + {1'b0, GRP_COUNT[gsel]};
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (grp_hit && !cls_hit && (8'(c) >= lo) && (8'(c) < hi) &&
			    ((w & CLS_MASK[c]) == CLS_MATCH[c])) begin
				cls_hit = 1'b1;
				cls     = 7'(c);
			end
		end
		return cls;
	endfunction

endpackage

// ===== design/la32r_instruction_decoder_top.sv =====
// LA32R instruction decoder: input register, table match and field decode, result register.
// A transfer that is accepted passes the input register, then the result register,
// and comes out of the result register with done high.
// Throughput: one instruction per cycle; busy stays low, so start may be held every cycle.
// The receiver cannot stall: done is high for exactly one cycle per result.
// Reset (arst_n low, asynchronous) clears both valid flags; payload registers are not reset.
module la32r_instruction_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  l32dec_pkg::item_t   item,
	output logic                done,
	output l32dec_pkg::result_t result
);
	import l32dec_pkg::*;

	item_t   item_s1;
	logic    vld_s1;
	result_t result_s2;
	logic    done_s2;
	result_t dec;

	logic [31:0] w;
	logic [31:0] pc;
	logic [4:0]  rd;
	logic [4:0]  rj;
	logic [4:0]  rk;
	logic [6:0]  cls;
	logic [4:0]  fmt;
	logic        dreg;
	logic        use_tgt;
	logic [31:0] imm;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		w   = item_s1.instr_word;
		pc  = item_s1.fetch_pc;
		rd  = w[4:0];
		rj  = w[9:5];
		rk  = w[14:10];
		cls = find_class(w);
		fmt = (cls == CLS_INVALID) ? FMT_NONE : CLS_FMT[cls[6:0]];

		dec             = '0;
		dreg            = 1'b0;
		use_tgt         = 1'b0;
		imm             = '0;
		dec.instr_class = cls;
		case (fmt)
			FMT_R3: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src1_reg = rj; dec.src2_reg = rk;
			end
			FMT_I12S: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src1_reg = rj;
				imm = {{20{w[21]}}, w[21:10]};
			end
			FMT_I12U: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src1_reg = rj;
				imm = {20'b0, w[21:10]};
			end
			FMT_I14S: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src2_reg = rj;
				imm = {{18{w[23]}}, w[23:10]};
			end
			FMT_CSR: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src2_reg = rj;
				imm = {18'b0, w[23:10]};
			end
			FMT_BR: begin
				dec.src1_reg = rj; dec.src2_reg = rd; use_tgt = 1'b1;
				imm = {{14{w[25]}}, w[25:10], 2'b00};
			end
			FMT_BL: begin
				dreg = 1'b1; dec.dest_reg = 5'd1; use_tgt = 1'b1;
				imm = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
			end
			FMT_B: begin
				use_tgt = 1'b1;
				imm = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
			end
			FMT_JIRL: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src1_reg = rj;
				imm = {{14{w[25]}}, w[25:10], 2'b00};
			end
			FMT_I5: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src1_reg = rj;
				imm = {27'b0, rk};
			end
			FMT_PCADD: begin
				dreg = 1'b1; dec.dest_reg = rd; use_tgt = 1'b1;
				imm = {w[24:5], 12'b0};
			end
			FMT_LU12I: begin
				dreg = 1'b1; dec.dest_reg = rd;
				imm = {w[24:5], 12'b0};
			end
			FMT_R2: begin
				dreg = 1'b1; dec.dest_reg = rd; dec.src1_reg = rj;
			end
			FMT_CODE: begin
				imm = {17'b0, w[14:0]};
			end
			FMT_INVTLB: begin
				dec.src1_reg = rk; dec.src2_reg = rj;
				imm = {27'b0, rd};
			end
			FMT_CACOP: begin
				dreg = 1'b1; dec.dest_reg = rj;
				imm = {{20{w[21]}}, w[21:10]};
			end
			default: begin
				dreg = 1'b0;
			end
		endcase
		dec.immediate   = imm;
		dec.dest_write  = dreg && (dec.dest_reg != 5'd0);
		dec.target_addr = use_tgt ? (pc + imm) : 32'd0;
		dec.link_addr   = (cls == CLS_INVALID) ? 32'd0 : (pc + 32'd4);

		// drop the decode on a misaligned fetch
		if (pc[1:0] != 2'b00) begin
			dec                  = '0;
			dec.fetch_misaligned = 1'b1;
			dec.instr_class      = CLS_INVALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			result_s2 <= dec;
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

`ifndef NO_ASSERTIONS
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted transfer did not produce a result");

	a_misaligned_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.fetch_misaligned) |->
		(result.instr_class == CLS_INVALID && result.link_addr == 32'd0))
		else $error("misaligned fetch decoded as a valid class");

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.instr_class == CLS_INVALID) |->
		(!result.dest_write && result.immediate == 32'sd0 && result.target_addr == 32'd0))
		else $error("invalid instruction carries decoded fields");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.dest_write) |-> (result.dest_reg != 5'd0))
		else $error("write enable set for r0");
`endif

endmodule

// ===== tb/la32r_instruction_decoder_top_tb.sv =====
// Self-checking testbench for the LA32R instruction decoder top level.
`timescale 1ns / 100ps

module la32r_instruction_decoder_top_tb;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int DRAIN_CYCLES     = 10;
	localparam int MAX_REPORTS      = 10;
	localparam int PHASES           = 4;
	localparam int RANDOM_PER_PHASE = 306;
	localparam int PHASE_IDLE [PHASES] = '{0, 60, 0, 29};

	localparam int N_GRP = l32dec_pkg::NUM_GROUPS;
	localparam int N_OPS = l32dec_pkg::NUM_CLASSES;

	localparam logic [4:0] LINK_REG = 5'd1;

	typedef enum logic [4:0] {
		OPF_NONE, OPF_R3, OPF_I12S, OPF_I12U, OPF_I14S, OPF_CSR, OPF_BR, OPF_B, OPF_BL,
		OPF_JIRL, OPF_I5, OPF_PCADD, OPF_LU12I, OPF_R2, OPF_CODE, OPF_INVTLB, OPF_CACOP
	} operand_fmt_e;

	typedef struct {
		l32dec_pkg::item_t instr;
		bit                wait_drain;
		int                idle_pct;
	} fetch_entry_t;

	// opcode groups, searched in order; the first hit picks the members to try
	localparam logic [31:0] grp_mask [N_GRP] = '{
		32'hFFF00000, 32'hF0000000, 32'hC0000000, 32'hFE000000, 32'hFFC00000,
		32'hFE000000, 32'hFE000000, 32'hFFF80000, 32'hFF000000, 32'hFFFFC000,
		32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFFFFFF, 32'hFFFFFFFF,
		32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF8000, 32'hFFFF8000,
		32'hFFFF8000, 32'hFFC00000, 32'hFFFFFFFF
	};
	localparam logic [31:0] grp_bits [N_GRP] = '{
		32'h00100000, 32'h20000000, 32'h40000000, 32'h02000000, 32'h00400000,
		32'h1C000000, 32'h14000000, 32'h00200000, 32'h04000000, 32'h00004000,
		32'h002B0000, 32'h002A0000, 32'h06488000, 32'h06483800, 32'h06482800,
		32'h06482C00, 32'h06483000, 32'h06483400, 32'h06498000, 32'h38720000,
		32'h38728000, 32'h06000000, 32'h80000000
	};
	localparam int grp_lo [N_GRP] = '{
		0, 14, 25, 34, 40, 43, 44, 45, 49, 52, 55, 56, 57, 58, 59, 60, 61, 62, 63, 64, 65, 66, 67
	};
	localparam int grp_n [N_GRP] = '{
		14, 11, 9, 6, 3, 1, 1, 4, 3, 3, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
	};

	localparam logic [31:0] op_mask [N_OPS] = '{
		32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000,
		32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000,
		32'h000F8000, 32'h000F8000, 32'h000F8000, 32'h000F8000,
		32'h0FC00000, 32'h0FC00000, 32'h0FC00000, 32'h0FC00000, 32'h0FC00000,
		32'h0FC00000, 32'h0FC00000, 32'h0FC00000, 32'h0FC00000, 32'h0F000000,
		32'h0F000000,
		32'h3C000000, 32'h3C000000, 32'h3C000000, 32'h3C000000, 32'h3C000000,
		32'h3C000000, 32'h3C000000, 32'h3C000000, 32'h3C000000,
		32'h01C00000, 32'h01C00000, 32'h01C00000, 32'h01C00000, 32'h01C00000,
		32'h01C00000,
		32'h003F8000, 32'h003F8000, 32'h003F8000,
		32'h00000000, 32'h00000000,
		32'h00078000, 32'h00078000, 32'h00078000, 32'h00078000,
		32'h000003E0, 32'h000003E0, 32'h00000000,
		32'h00003FE0, 32'h00003FE0, 32'h00003C1F,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000
	};
	localparam logic [31:0] op_bits [N_OPS] = '{
		32'h00000000, 32'h00010000, 32'h00048000, 32'h00050000, 32'h00058000,
		32'h00040000, 32'h00020000, 32'h00028000, 32'h00070000, 32'h00078000,
		32'h00080000, 32'h000C0000, 32'h000C8000, 32'h000D0000,
		32'h08800000, 32'h09800000, 32'h08400000, 32'h0A400000, 32'h09400000,
		32'h08000000, 32'h0A000000, 32'h09000000, 32'h0AC00000, 32'h00000000,
		32'h01000000,
		32'h10000000, 32'h2C000000, 32'h1C000000, 32'h24000000, 32'h20000000,
		32'h18000000, 32'h28000000, 32'h14000000, 32'h0C000000,
		32'h00800000, 32'h00000000, 32'h01400000, 32'h01800000, 32'h01C00000,
		32'h00400000,
		32'h00008000, 32'h00048000, 32'h00088000,
		32'h00000000, 32'h00000000,
		32'h00000000, 32'h00010000, 32'h00008000, 32'h00018000,
		32'h00000000, 32'h00000020, 32'h00000000,
		32'h00002000, 32'h00002400, 32'h00002000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000
	};
	localparam operand_fmt_e op_fmt [N_OPS] = '{
		OPF_R3, OPF_R3, OPF_R3, OPF_R3, OPF_R3, OPF_R3, OPF_R3, OPF_R3,
		OPF_R3, OPF_R3, OPF_R3, OPF_R3, OPF_R3, OPF_R3,
		OPF_I12S, OPF_I12S, OPF_I12S, OPF_I12S, OPF_I12S, OPF_I12S,
		OPF_I12S, OPF_I12S, OPF_I12S, OPF_I14S, OPF_I14S,
		OPF_B, OPF_BR, OPF_BR, OPF_BR, OPF_BR, OPF_BR, OPF_BR, OPF_BL, OPF_JIRL,
		OPF_I12S, OPF_I12S, OPF_I12U, OPF_I12U, OPF_I12U, OPF_I12S,
		OPF_I5, OPF_I5, OPF_I5,
		OPF_PCADD, OPF_LU12I,
		OPF_R3, OPF_R3, OPF_R3, OPF_R3,
		OPF_CSR, OPF_CSR, OPF_CSR,
		OPF_R2, OPF_R2, OPF_R2,
		OPF_CODE, OPF_CODE, OPF_CODE,
		OPF_NONE, OPF_NONE, OPF_NONE, OPF_NONE, OPF_NONE,
		OPF_INVTLB, OPF_NONE, OPF_NONE, OPF_CACOP, OPF_NONE
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	l32dec_pkg::item_t   item = '0;
	logic                done;
	l32dec_pkg::result_t result;

	fetch_entry_t        fetch_q [$];
	l32dec_pkg::result_t expected_decodes [$];
	int                  issued_count = 0;
	int                  retired_count = 0;
	int                  mismatch_count = 0;
	int                  cycle_count = 0;
	int                  invalid_count = 0;
	int                  misaligned_count = 0;
	bit                  class_hit [N_OPS+1];

	la32r_instruction_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic l32dec_pkg::result_t decode_instr(l32dec_pkg::item_t it);
		l32dec_pkg::result_t r;
		logic [31:0] w;
		logic [31:0] pc;
		logic [31:0] imm;
		logic [4:0]  rd;
		logic [4:0]  rj;
		logic [4:0]  rk;
		logic [4:0]  dst;
		bit          wr;
		int          grp;
		int          op;
		r   = '0;
		w   = it.instr_word;
		pc  = it.fetch_pc;
		rd  = w[4:0];
		rj  = w[9:5];
		rk  = w[14:10];
		dst = '0;
		imm = '0;
		wr  = 1'b0;
		r.instr_class = l32dec_pkg::CLS_INVALID;
		// misaligned fetch: the word is not looked at
		if (pc[1:0] != 2'b00) begin
			r.fetch_misaligned = 1'b1;
			return r;
		end
		grp = -1;
		for (int g = 0; g < N_GRP; g++)
			if (grp < 0 && (w & grp_mask[g]) == grp_bits[g])
				grp = g;
		// a miss inside the chosen group is invalid; later groups are not tried
		op = N_OPS;
		if (grp >= 0)
			for (int k = grp_lo[grp]; k < grp_lo[grp] + grp_n[grp]; k++)
				if (op == N_OPS && (w & op_mask[k]) == op_bits[k])
					op = k;
		if (op == N_OPS)
			return r;
		r.instr_class = 7'(op);
		r.link_addr   = pc + 32'd4;
		case (op_fmt[op])
			OPF_R3: begin
				wr = 1'b1; dst = rd; r.src1_reg = rj; r.src2_reg = rk;
			end
			OPF_I12S: begin
				wr = 1'b1; dst = rd; r.src1_reg = rj; imm = {{20{w[21]}}, w[21:10]};
			end
			OPF_I12U: begin
				wr = 1'b1; dst = rd; r.src1_reg = rj; imm = {20'b0, w[21:10]};
			end
			OPF_I14S: begin
				wr = 1'b1; dst = rd; r.src2_reg = rj; imm = {{18{w[23]}}, w[23:10]};
			end
			OPF_CSR: begin
				wr = 1'b1; dst = rd; r.src2_reg = rj; imm = {18'b0, w[23:10]};
			end
			OPF_BR: begin
				r.src1_reg = rj; r.src2_reg = rd;
				imm = {{14{w[25]}}, w[25:10], 2'b00};
				r.target_addr = pc + imm;
			end
			OPF_BL: begin
				wr = 1'b1; dst = LINK_REG;
				imm = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
				r.target_addr = pc + imm;
			end
			OPF_B: begin
				imm = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
				r.target_addr = pc + imm;
			end
			OPF_JIRL: begin
				// target depends on rj contents, so none is reported
				wr = 1'b1; dst = rd; r.src1_reg = rj; imm = {{14{w[25]}}, w[25:10], 2'b00};
			end
			OPF_I5: begin
				wr = 1'b1; dst = rd; r.src1_reg = rj; imm = {27'b0, rk};
			end
			OPF_PCADD: begin
				wr = 1'b1; dst = rd; imm = {w[24:5], 12'b0};
				r.target_addr = pc + imm;
			end
			OPF_LU12I: begin
				wr = 1'b1; dst = rd; imm = {w[24:5], 12'b0};
			end
			OPF_R2: begin
				wr = 1'b1; dst = rd; r.src1_reg = rj;
			end
			OPF_CODE: imm = {17'b0, w[14:0]};
			OPF_INVTLB: begin
				r.src1_reg = rk; r.src2_reg = rj; imm = {27'b0, rd};
			end
			OPF_CACOP: begin
				wr = 1'b1; dst = rj; imm = {{20{w[21]}}, w[21:10]};
			end
			default: ;
		endcase
		r.dest_reg   = dst;
		r.dest_write = wr && (dst != 5'd0);
		r.immediate  = imm;
		return r;
	endfunction

	function automatic logic [31:0] fill_pattern(logic [31:0] mask, logic [31:0] bits);
		return ($urandom() & ~mask) | bits;
	endfunction

	task automatic queue_item(input logic [31:0] w, input logic [31:0] pc,
			input bit drain_first, input int idle_pct);
		fetch_entry_t e;
		e.instr.instr_word = w;
		e.instr.fetch_pc   = pc;
		e.wait_drain       = drain_first;
		e.idle_pct         = idle_pct;
		fetch_q.push_back(e);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want, inout bit bad);
		if (got !== want) begin
			if (!bad)
				mismatch_count++;
			bad = 1'b1;
			if (mismatch_count <= MAX_REPORTS)
				$display("decode %0d: %s expected %h got %h", retired_count, name, want, got);
		end
	endtask

	// driver: issue the next pending instruction unless idling or holding for a drain
	always @(posedge clk) begin
		l32dec_pkg::result_t want;
		bit accepted;
		bit hold;
		accepted = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				accepted = 1'b1;
				want = decode_instr(item);
				expected_decodes.push_back(want);
				class_hit[want.instr_class] = 1'b1;
				if (want.fetch_misaligned)
					misaligned_count++;
				else if (want.instr_class == l32dec_pkg::CLS_INVALID)
					invalid_count++;
				issued_count <= issued_count + 1;
				fetch_q.delete(0);
			end
			if (fetch_q.size() == 0) begin
				start <= 1'b0;
			end else begin
				hold = fetch_q[0].wait_drain && (accepted || issued_count != retired_count);
				if (!hold && $urandom_range(99, 0) >= fetch_q[0].idle_pct) begin
					start <= 1'b1;
					item  <= fetch_q[0].instr;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every done cycle carries one decode, checked against the oldest prediction
	always @(posedge clk) begin
		l32dec_pkg::result_t want;
		bit bad;
		bad = 1'b0;
		if (arst_n && done) begin
			retired_count <= retired_count + 1;
			if (expected_decodes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("decode %0d: unexpected result, class %0d",
						retired_count, result.instr_class);
			end else begin
				want = expected_decodes.pop_front();
				check_field("fetch_misaligned", 32'(result.fetch_misaligned),
					32'(want.fetch_misaligned), bad);
				check_field("instr_class", 32'(result.instr_class),
					32'(want.instr_class), bad);
				check_field("dest_reg", 32'(result.dest_reg), 32'(want.dest_reg), bad);
				check_field("dest_write", 32'(result.dest_write), 32'(want.dest_write), bad);
				check_field("src1_reg", 32'(result.src1_reg), 32'(want.src1_reg), bad);
				check_field("src2_reg", 32'(result.src2_reg), 32'(want.src2_reg), bad);
				check_field("immediate", result.immediate, want.immediate, bad);
				check_field("target_addr", result.target_addr, want.target_addr, bad);
				check_field("link_addr", result.link_addr, want.link_addr, bad);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d decodes outstanding",
				cycle_count, issued_count - retired_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] w;
		logic [31:0] pc;
		int          pick;
		int          op;
		int          g;
		int          covered;

		// directed: field extremes and corner cases
		queue_item(32'h00100820, 32'h00000000, 1'b0, 0);  // add.w into r0, no write
		queue_item(32'h00100825, 32'h00001001, 1'b0, 0);  // misaligned fetch
		queue_item(32'h00100825, 32'h00001002, 1'b0, 0);
		queue_item(32'h00100825, 32'hFFFFFFFF, 1'b0, 0);
		queue_item(32'h80000000, 32'h00000000, 1'b0, 0);  // trap word
		queue_item(32'h06483800, 32'h00000010, 1'b0, 0);  // ertn
		queue_item(32'h06482800, 32'h00000014, 1'b0, 0);  // tlbsrch
		queue_item(32'h001F8000, 32'h00000018, 1'b0, 0);  // group hit, no member
		queue_item(32'h00000000, 32'h0000001C, 1'b0, 0);  // no group
		queue_item(32'hFFFFFFFF, 32'hFFFFFFFC, 1'b0, 0);
		queue_item(32'h54000200, 32'h00000000, 1'b0, 0);  // bl, most negative offset
		queue_item(32'h57FFFDFF, 32'hFFFFFFFC, 1'b0, 0);  // bl, largest offset, pc wraps
		queue_item(32'h53FFFFFF, 32'h00000004, 1'b0, 0);  // b, offset -1
		queue_item(32'h5A000064, 32'h00000000, 1'b0, 0);  // beq, most negative offset
		queue_item(32'h4DFFFC21, 32'h7FFFFFF0, 1'b0, 0);  // jirl, no target
		queue_item(32'h1DFFFFFF, 32'h80000000, 1'b0, 0);  // pcaddu12i, si20 all ones
		queue_item(32'h15000007, 32'h00000040, 1'b0, 0);  // lu12i.w, si20 sign bit
		queue_item(32'h02A003FF, 32'h00000044, 1'b0, 0);  // addi.w, si12 sign bit
		queue_item(32'h037FFC02, 32'h00000048, 1'b0, 0);  // andi, ui12 all ones
		queue_item(32'h208000A6, 32'h0000004C, 1'b0, 0);  // ll.w, si14 sign bit
		queue_item(32'h04FFFC43, 32'h00000050, 1'b0, 0);  // csrxchg
		queue_item(32'h00006080, 32'h00000054, 1'b0, 0);  // rdcntid.w, rd stays r0
		queue_item(32'h00006409, 32'h00000058, 1'b0, 0);  // rdcntvh.w
		queue_item(32'h06499C7F, 32'h0000005C, 1'b0, 0);  // invtlb
		queue_item(32'h0620011F, 32'h00000060, 1'b0, 0);  // cacop, dest is rj
		queue_item(32'h002B7FFF, 32'h00000064, 1'b0, 0);  // syscall, code all ones
		queue_item(32'h0040FC22, 32'h00000068, 1'b0, 0);  // slli.w, ui5 = 31
		queue_item(32'h00207FFF, 32'h0000006C, 1'b0, 0);  // div.w, all registers r31

		// random: mostly well-formed words, mixed with group-only hits and raw noise
		for (int p = 0; p < PHASES; p++) begin
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				pick = $urandom_range(99, 0);
				pc   = $urandom();
				if ($urandom_range(15, 0) != 0)
					pc[1:0] = 2'b00;
				if ($urandom_range(31, 0) == 0)
					pc = 32'hFFFFFFFC;
				// sweep every class once before picking at random
				if (p == 0 && n < N_OPS)
					op = n;
				else
					op = $urandom_range(N_OPS - 1, 0);
				g = 0;
				for (int k = 0; k < N_GRP; k++)
					if (op >= grp_lo[k] && op < grp_lo[k] + grp_n[k])
						g = k;
				if (pick < 75 || (p == 0 && n < N_OPS))
					w = fill_pattern(grp_mask[g] | op_mask[op], grp_bits[g] | op_bits[op]);
				else if (pick < 88)
					w = fill_pattern(grp_mask[g], grp_bits[g]);
				else
					w = $urandom();
				queue_item(w, pc, n == 0, PHASE_IDLE[p]);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
			#1;
		end while (fetch_q.size() != 0 || start || issued_count != retired_count);
		repeat (DRAIN_CYCLES) @(posedge clk);
		#1;
		if (expected_decodes.size() != 0) begin
			$display("%0d predicted decodes never came out", expected_decodes.size());
			mismatch_count += expected_decodes.size();
		end

		covered = 0;
		for (int c = 0; c < N_OPS; c++)
			if (class_hit[c])
				covered++;
		$display("Decoded %0d instructions in %0d cycles: %0d of %0d classes seen,",
			issued_count, cycle_count, covered, N_OPS);
		$display("%0d invalid words, %0d misaligned fetches, %0d mismatching decodes.",
			invalid_count, misaligned_count, mismatch_count);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
design/l32dec_pkg.sv
design/la32r_instruction_decoder_top.sv
tb/la32r_instruction_decoder_top_tb.sv
